/* design/wemc_pkg.sv */
// Package for weighted_equalize_min_cost: request/result structs and widths.
// No dependencies.
package wemc_pkg;
    localparam int HEIGHT_W = 16;
    localparam int COST_W   = 16;
    localparam int TOTAL_W  = 40;
    localparam int PROD_W   = HEIGHT_W + COST_W;
    localparam int ACC_W    = 64;

    typedef struct packed {
        logic [HEIGHT_W-1:0] tower_height;
        logic [COST_W-1:0]   unit_cost;
        logic                last_tower;
    } wemc_req_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total_cost;
        logic               dropped;
    } wemc_res_t;

    typedef struct packed {
        logic                valid;
        logic [HEIGHT_W-1:0] height;
        logic [COST_W-1:0]   cost;
    } wemc_tower_t;

    // Sorting chain command to every cell
    typedef struct packed {
        logic                ins;
        logic                shift;
        logic                clear;
        logic [HEIGHT_W-1:0] height;
        logic [COST_W-1:0]   cost;
    } wemc_cmd_t;
endpackage

/* design/wemc_cell.sv */
// One cell of the sorted tower chain.
// Depends on wemc_pkg.
module wemc_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  wemc_pkg::wemc_cmd_t   cmd,
    input  wemc_pkg::wemc_tower_t left,
    input  logic                  left_goes,
    output wemc_pkg::wemc_tower_t held,
    output logic                  goes
);
    import wemc_pkg::*;

    logic                valid_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [COST_W-1:0]   cost_reg;

    // A valid cell yields its place when the new height is smaller.
    assign goes = valid_reg && (height_reg > cmd.height);
    assign held = '{valid: valid_reg, height: height_reg, cost: cost_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.shift)
        begin
            valid_reg <= left.valid;
        end
        else if (cmd.ins)
        begin
            if (left_goes || (!valid_reg && !(left.valid && !left_goes) && left.valid) ||
                (!valid_reg && left.valid))
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            height_reg <= left.height;
            cost_reg   <= left.cost;
        end
        else if (cmd.ins)
        begin
            if (left_goes)
            begin
                height_reg <= left.height;
                cost_reg   <= left.cost;
            end
            else if (goes || (!valid_reg && left.valid))
            begin
                height_reg <= cmd.height;
                cost_reg   <= cmd.cost;
            end
        end
    end
endmodule

/* design/wemc_scan.sv */
// Cost scan: two passes over the towers shifted out of the chain.
// Depends on wemc_pkg.
module wemc_scan
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  begin_pass,
    input  logic                  second,
    input  logic                  step,
    input  wemc_pkg::wemc_tower_t tower,
    output logic [wemc_pkg::TOTAL_W-1:0] best
);
    import wemc_pkg::*;

    localparam int MUL_W = HEIGHT_W + 32;

    logic [ACC_W-1:0]  all_c_reg, all_hc_reg, pc_reg, phc_reg, best_reg;
    logic              have_reg;
    logic [PROD_W-1:0] tc;
    logic [MUL_W-1:0]  t_pc, t_sc;
    logic [ACC_W-1:0]  c64, tc64, sc, shc, lft, rgt, tot;

    // Towers arrive tallest first, so the prefix holds the taller towers.
    assign tc   = tower.height * tower.cost;
    assign c64  = ACC_W'(tower.cost);
    assign tc64 = ACC_W'(tc);
    assign sc   = all_c_reg - pc_reg - c64;
    assign shc  = all_hc_reg - phc_reg - tc64;
    assign t_pc = MUL_W'(tower.height) * MUL_W'(pc_reg[31:0]);
    assign t_sc = MUL_W'(tower.height) * MUL_W'(sc[31:0]);
    assign lft  = phc_reg - ACC_W'(t_pc);
    assign rgt  = ACC_W'(t_sc) - shc;
    assign tot  = lft + rgt;
    assign best = (best_reg > ACC_W'({TOTAL_W{1'b1}})) ? {TOTAL_W{1'b1}}
                                                        : best_reg[TOTAL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_c_reg  <= '0;
            all_hc_reg <= '0;
            pc_reg     <= '0;
            phc_reg    <= '0;
            best_reg   <= '0;
            have_reg   <= 1'b0;
        end
        else if (begin_pass)
        begin
            if (!second)
            begin
                all_c_reg  <= '0;
                all_hc_reg <= '0;
                best_reg   <= '0;
                have_reg   <= 1'b0;
            end
            pc_reg  <= '0;
            phc_reg <= '0;
        end
        else if (step && tower.valid)
        begin
            if (!second)
            begin
                all_c_reg  <= all_c_reg + c64;
                all_hc_reg <= all_hc_reg + tc64;
            end
            else
            begin
                if (!have_reg || tot < best_reg)
                begin
                    best_reg <= tot;
                end
                have_reg <= 1'b1;
                pc_reg   <= pc_reg + c64;
                phc_reg  <= phc_reg + tc64;
            end
        end
    end
endmodule

/* design/weighted_equalize_min_cost.sv */
// Top level of weighted_equalize_min_cost: sorted cell chain plus cost scan.
// Depends on wemc_pkg, wemc_cell, wemc_scan.
//
//  channel  | ports                      | handshake
//  request  | start, busy, req           | taken when start && !busy
//  result   | done, res                  | one-cycle strobe, no stall
//
// The chain inserts each tower request in sorted place.
// A last request starts the scan: two rotations of the chain (PASS1, PASS2),
// then a clearing state (FINISH); busy stays high through all three, and
// done pulses in the same cycle as busy falls.
// Reset empties the chain. The receiver cannot stall results.
module weighted_equalize_min_cost
#(
    parameter int MAX_TOWERS = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  wemc_pkg::wemc_req_t  req,
    output logic                 busy,
    output logic                 done,
    output wemc_pkg::wemc_res_t  res
);
    import wemc_pkg::*;

    localparam int CNT_W = $clog2(MAX_TOWERS + 1);

    typedef enum logic [1:0] {IDLE, PASS1, PASS2, FINISH} state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg, step_reg;
    logic               over_reg;
    logic               done_reg;
    logic               dropped_reg;

    wemc_cmd_t          cmd;
    wemc_tower_t        held [MAX_TOWERS];
    wemc_tower_t        lefts [MAX_TOWERS];
    logic               goes [MAX_TOWERS];
    logic               lgoes [MAX_TOWERS];
    logic               accept, full, rotating, begin_pass;
    logic [TOTAL_W-1:0] best;

    assign accept   = start && !busy;
    assign full     = (count_reg == CNT_W'(MAX_TOWERS));
    assign rotating = (state_reg == PASS1) || (state_reg == PASS2);
    assign busy     = (state_reg != IDLE);

    assign cmd.ins    = accept && !full;
    assign cmd.shift  = rotating;
    assign cmd.clear  = (state_reg == FINISH);
    assign cmd.height = req.tower_height;
    assign cmd.cost   = req.unit_cost;

    // Rotate the chain: the last cell feeds the first during the scan.
    genvar g;
    generate
        for (g = 0; g < MAX_TOWERS; g++)
        begin : g_chain
            if (g == 0)
            begin : g_head
                always_comb
                begin
                    if (rotating)
                    begin
                        lefts[g] = held[MAX_TOWERS-1];
                    end
                    else
                    begin
                        lefts[g] = '{valid: 1'b1, height: req.tower_height,
                                     cost: req.unit_cost};
                    end
                end
                assign lgoes[g] = 1'b0;
            end
            else
            begin : g_body
                assign lefts[g] = held[g-1];
                assign lgoes[g] = goes[g-1];
            end
            wemc_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .left      (lefts[g]),
                .left_goes (lgoes[g]),
                .held      (held[g]),
                .goes      (goes[g])
            );
        end
    endgenerate

    // Valid towers sit in the low cells; outside the scan cell zero's left input is the new request,
    // so the first empty cell takes it through the !valid && left.valid path.

    assign begin_pass = accept && req.last_tower;

    wemc_scan u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .begin_pass (begin_pass),
        .second     (state_reg == PASS2),
        .step       (rotating),
        .tower      (held[MAX_TOWERS-1]),
        .best       (best)
    );

    assign done           = done_reg;
    assign res.total_cost = best;
    assign res.dropped    = dropped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= IDLE;
            count_reg   <= '0;
            step_reg    <= '0;
            over_reg    <= 1'b0;
            done_reg    <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        if (!full)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        if (req.last_tower)
                        begin
                            dropped_reg <= over_reg || full;
                            step_reg    <= '0;
                            state_reg   <= PASS1;
                        end
                        else if (full)
                        begin
                            over_reg <= 1'b1;
                        end
                    end
                end
                PASS1:
                begin
                    step_reg <= step_reg + CNT_W'(1);
                    if (step_reg == CNT_W'(MAX_TOWERS - 1))
                    begin
                        step_reg  <= '0;
                        state_reg <= PASS2;
                    end
                end
                PASS2:
                begin
                    step_reg <= step_reg + CNT_W'(1);
                    if (step_reg == CNT_W'(MAX_TOWERS - 1))
                    begin
                        state_reg <= FINISH;
                    end
                end
                FINISH:
                begin
                    done_reg  <= 1'b1;
                    count_reg <= '0;
                    over_reg  <= 1'b0;
                    state_reg <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end
endmodule

/* tb/weighted_equalize_min_cost_chk.sv */
// Checker for weighted_equalize_min_cost: watches the request and result channels,
// predicts the minimum weighted equalize cost per set and compares. Depends on wemc_pkg.
module weighted_equalize_min_cost_chk
#(
    parameter int MAX_TOWERS = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  wemc_pkg::wemc_req_t  req,
    input  logic                 done,
    input  wemc_pkg::wemc_res_t  res,
    output int                   fail_count,
    output int                   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import wemc_pkg::*;

    logic [HEIGHT_W-1:0] tower_h[$];
    logic [COST_W-1:0]   tower_c[$];
    logic                set_dropped;
    wemc_res_t           expected_totals[$];

    // Order does not matter for the total, so keep arrival order and scan directly.
    function automatic wemc_res_t min_equalize_cost(input logic drop_flag);
        wemc_res_t     r;
        logic [63:0]   best;
        logic [63:0]   tot;
        logic [63:0]   d;
        best = '1;
        for (int i = 0; i < tower_h.size(); i++)
        begin
            tot = 0;
            for (int k = 0; k < tower_h.size(); k++)
            begin
                d = (tower_h[k] > tower_h[i]) ? 64'(tower_h[k] - tower_h[i])
                                              : 64'(tower_h[i] - tower_h[k]);
                tot += d * 64'(tower_c[k]);
            end
            if (tot < best)
                best = tot;
        end
        if (tower_h.size() == 0)
            best = 0;
        if (best > 64'hFF_FFFF_FFFF)
            best = 64'hFF_FFFF_FFFF;
        r.total_cost = best[TOTAL_W-1:0];
        r.dropped = drop_flag;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wemc_res_t exp_r;
        if (!rst_n)
        begin
            tower_h.delete();
            tower_c.delete();
            set_dropped = 1'b0;
            expected_totals.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_totals.size() == 0)
                begin
                    $error("unexpected result total_cost=%0d", res.total_cost);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_totals.pop_front();
                    if (res.total_cost !== exp_r.total_cost)
                    begin
                        $error("total_cost expected %0d actual %0d",
                               exp_r.total_cost, res.total_cost);
                        fail_count++;
                    end
                    if (res.dropped !== exp_r.dropped)
                    begin
                        $error("dropped expected %0d actual %0d", exp_r.dropped, res.dropped);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (tower_h.size() < MAX_TOWERS)
                begin
                    tower_h = {tower_h, req.tower_height};
                    tower_c = {tower_c, req.unit_cost};
                end
                else
                    set_dropped = 1'b1;
                if (req.last_tower)
                begin
                    expected_totals = {expected_totals, min_equalize_cost(set_dropped)};
                    tower_h.delete();
                    tower_c.delete();
                    set_dropped = 1'b0;
                end
            end
            pending_count = expected_totals.size();
        end
    end
endmodule

/* tb/weighted_equalize_min_cost_tb.sv */
// Testbench top for weighted_equalize_min_cost: drives tower requests and gives the verdict.
// Depends on wemc_pkg, weighted_equalize_min_cost, weighted_equalize_min_cost_chk.
module weighted_equalize_min_cost_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wemc_pkg::*;

    localparam int MAX_TOWERS = 256;
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef logic bool_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    wemc_req_t req;
    logic      busy;
    logic      done;
    wemc_res_t res;
    int        fail_count;
    int        pending_count;
    int        cycle_count;
    bool_t     no_idle;

    weighted_equalize_min_cost #(.MAX_TOWERS(MAX_TOWERS)) i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .res   (res)
    );

    weighted_equalize_min_cost_chk #(.MAX_TOWERS(MAX_TOWERS)) i_chk
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req           (req),
        .done          (done),
        .res           (res),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("weighted_equalize_min_cost test failed");
            $finish;
        end
    end

    // Hold one request until the block takes it, with random idle cycles before it.
    task automatic send_tower(input logic [15:0] h, input logic [15:0] c, input logic last);
        while (!no_idle && $urandom_range(0, 99) < 21)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req.tower_height <= h;
        req.unit_cost <= c;
        req.last_tower <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_set(input int n, input int mode);
        logic [15:0] h;
        logic [15:0] c;
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                0: begin h = 16'($urandom); c = 16'($urandom); end
                1: begin h = 16'($urandom_range(0, 15)); c = 16'($urandom_range(0, 7)); end
                default: begin h = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                               c = 16'hFFFF; end
            endcase
            send_tower(h, c, i == n - 1);
        end
    endtask

    initial
    begin
        int items;
        int n;
        cycle_count = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: single towers at the extremes, equal heights, wide spread
        send_tower(16'h0000, 16'h0000, 1'b1);
        send_tower(16'hFFFF, 16'hFFFF, 1'b1);
        send_tower(16'h0000, 16'hFFFF, 1'b0);
        send_tower(16'hFFFF, 16'hFFFF, 1'b1);
        send_tower(16'h0007, 16'h0003, 1'b0);
        send_tower(16'h0007, 16'h0009, 1'b0);
        send_tower(16'h0007, 16'h0001, 1'b1);
        send_tower(16'h0009, 16'h0001, 1'b0);
        send_tower(16'h0003, 16'h0005, 1'b0);
        send_tower(16'h0005, 16'h0002, 1'b0);
        send_tower(16'h0001, 16'h0000, 1'b1);
        send_tower(16'hAAAA, 16'h5555, 1'b0);
        send_tower(16'h5555, 16'hAAAA, 1'b1);
        // Full store: extreme-value set (heights 0 or FFFF, cost FFFF) plus overflow, the last one dropped too
        send_set(MAX_TOWERS + 3, 2);

        items = 0;
        while (items < 700)
        begin
            no_idle = (items >= 300 && items < 400);
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_TOWERS - 2, MAX_TOWERS + 4)
                                             : $urandom_range(1, 12);
            send_set(n, $urandom_range(0, 9) == 0 ? 2 : $urandom_range(0, 1));
            items += n;
        end
        start <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (2 * MAX_TOWERS + 10) @(posedge clk);
        if (fail_count == 0)
            $display("weighted_equalize_min_cost test passed");
        else
            $display("weighted_equalize_min_cost test failed");
        $finish;
    end
endmodule

/* files.f */
design/wemc_pkg.sv
design/wemc_cell.sv
design/wemc_scan.sv
design/weighted_equalize_min_cost.sv
tb/weighted_equalize_min_cost_chk.sv
tb/weighted_equalize_min_cost_tb.sv
